// ===== hdl/mhdm_pkg.sv =====
`default_nettype none
// Shared constants, types and helpers for the max-heap delete-max core.
package mhdm_pkg;

  localparam int unsigned HEAP_DEPTH = 128;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned LEVELS     = $clog2(HEAP_DEPTH);
  localparam int unsigned CNT_W      = LEVELS;
  localparam int unsigned LVL_W      = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int unsigned OUT_CNT_W  = 7;
  localparam int unsigned STATUS_W   = 2;

  typedef logic [CNT_W-1:0]         idx_t;
  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [LVL_W-1:0]         lvl_t;

  typedef enum logic [0:0] {
    OP_APPEND = 1'b0,
    OP_DELETE = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_SIFT
  } state_t;

  // A moving entry: the parent slot it currently sits in and its value.
  typedef struct packed {
    logic  valid;
    idx_t  idx;
    data_t value;
  } tok_t;

  // A write into one level's storage, addressed by heap index.
  typedef struct packed {
    logic  valid;
    idx_t  idx;
    data_t value;
  } wr_t;

  typedef struct packed {
    logic  we;
    idx_t  widx;
    data_t wdata;
    idx_t  ra;
    idx_t  rb;
  } ram_req_t;

  // Level of a heap index is the position of its leading one.
  function automatic lvl_t lvl_of(idx_t x);
    lvl_t pos;
    pos = '0;
    for (int i = 0; i < CNT_W; i++) begin
      if (x[i]) pos = LVL_W'(i);
    end
    return pos;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/mhdm_ram.sv =====
`default_nettype none
// Generic RAM with one write port and two registered read ports.
module mhdm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic                                        clk,
  input  wire logic                                        we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                            wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
  output logic      [WIDTH-1:0]                            rdata_a,
  output logic      [WIDTH-1:0]                            rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
`default_nettype wire

// ===== hdl/mhdm_cell.sv =====
`default_nettype none
// One heap level: reads both children, keeps the larger in the parent slot, passes on.
module mhdm_cell
  import mhdm_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire idx_t     count,
  input  wire tok_t     tok_in,
  output tok_t          tok_out,
  input  wire wr_t      wb_in,
  output wr_t           wb_out,
  input  wire wr_t      host_wr,
  input  wire idx_t     host_rd_idx,
  output data_t         host_rd_data,
  output logic          busy,
  output ram_req_t      ram_req,
  input  wire data_t    ram_rdata_a,
  input  wire data_t    ram_rdata_b
);

  logic  pend;
  idx_t  par_idx;
  data_t val;

  idx_t  lidx;
  idx_t  ridx;
  logic  l_win;
  logic  r_win;
  data_t cand;
  logic  win;
  idx_t  win_idx;
  data_t win_val;
  wr_t   own_wr;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= tok_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_in.valid) begin
      par_idx <= tok_in.idx;
      val     <= tok_in.value;
    end
  end

  // Children of the held parent live in this level; the read data arrives now.
  always_comb begin
    lidx    = {par_idx[CNT_W-2:0], 1'b0};
    ridx    = {par_idx[CNT_W-2:0], 1'b1};
    l_win   = (lidx <= count) && ($signed(ram_rdata_a) > $signed(val));
    cand    = l_win ? ram_rdata_a : val;
    r_win   = (ridx <= count) && ($signed(ram_rdata_b) > $signed(cand));
    win     = pend && (l_win || r_win);
    win_idx = r_win ? ridx : lidx;
    win_val = r_win ? ram_rdata_b : ram_rdata_a;
  end

  // On a swap the child moves up and the moving entry drops into the child slot.
  always_comb begin
    wb_out  = '{valid: win, idx: par_idx, value: win_val};
    own_wr  = '{valid: win, idx: win_idx, value: val};
    tok_out = '{valid: win, idx: win_idx, value: val};
  end

  always_comb begin
    if (host_wr.valid) begin
      ram_req.we    = 1'b1;
      ram_req.widx  = host_wr.idx;
      ram_req.wdata = host_wr.value;
    end else if (own_wr.valid) begin
      ram_req.we    = 1'b1;
      ram_req.widx  = own_wr.idx;
      ram_req.wdata = own_wr.value;
    end else begin
      ram_req.we    = wb_in.valid;
      ram_req.widx  = wb_in.idx;
      ram_req.wdata = wb_in.value;
    end
    ram_req.ra = tok_in.valid ? {tok_in.idx[CNT_W-2:0], 1'b0} : host_rd_idx;
    ram_req.rb = {tok_in.idx[CNT_W-2:0], 1'b1};
  end

  assign host_rd_data = ram_rdata_a;
  assign busy         = pend;

endmodule
`default_nettype wire

// ===== hdl/max_heap_delete_max_core.sv =====
`default_nettype none
// Top level of the binary max-heap: controller, root register and the chain of level cells.
//
//   channel   handshake             fields
//   request   req_valid/req_stall   func, value
//   response  rsp_valid/rsp_stall   max_value, status, entry_count_out
//
// Every result is computed when its request word is accepted and is registered in the
// response register, or in the skid word while a response is stalled. Appends and
// deletes from a heap of zero or one entries need no sift. A larger delete fetches the
// last entry, then sinks it level by level through the cell chain while requests stall.
// Reset clears the entry count and control state; the level memories are not cleared.
// A response register and a skid word let one more request in while a response is stalled.
module max_heap_delete_max_core
  import mhdm_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   req_valid,
  output logic                        req_stall,
  input  wire logic [0:0]             func,
  input  wire logic signed [DATA_W-1:0] value,
  output logic                        rsp_valid,
  input  wire logic                   rsp_stall,
  output logic signed [DATA_W-1:0]    max_value,
  output logic [STATUS_W-1:0]         status,
  output logic [OUT_CNT_W-1:0]        entry_count_out
);

  state_t state;
  state_t state_next;
  idx_t   count;
  data_t  root;
  lvl_t   lvl_q;

  logic    acc;
  logic    is_del;
  logic    app_ok;
  logic    app_wr;
  idx_t    app_idx;
  lvl_t    app_lvl;
  logic    start_sift;
  data_t   res_max;
  status_t res_status;
  idx_t    res_count;
  tok_t    tok_launch;

  logic    skid_valid;
  data_t   skid_max;
  status_t skid_status;
  idx_t    skid_count;
  data_t   out_max;
  status_t out_status;
  idx_t    out_count;

  tok_t     tok_in_arr  [1:LEVELS-1];
  tok_t     tok_out_arr [1:LEVELS-1];
  wr_t      wb_in_arr   [1:LEVELS-1];
  wr_t      wb_out_arr  [1:LEVELS-1];
  wr_t      host_wr_arr [1:LEVELS-1];
  ram_req_t ram_req_arr [1:LEVELS-1];
  data_t    rda_arr     [1:LEVELS-1];
  data_t    rdb_arr     [1:LEVELS-1];
  data_t    rd_arr      [LEVELS];
  logic [LEVELS-1:1] busy_vec;

  assign req_stall = (state != S_IDLE) || skid_valid;
  assign acc       = req_valid && !req_stall;
  assign is_del    = op_t'(func) == OP_DELETE;
  assign app_ok    = count < idx_t'(HEAP_DEPTH - 1);
  assign app_idx   = count + idx_t'(1);
  assign app_lvl   = lvl_of(app_idx);
  assign app_wr    = acc && !is_del && app_ok;
  assign start_sift = acc && is_del && (count > idx_t'(1));

  always_comb begin
    res_max    = '0;
    res_status = ST_OK;
    res_count  = count;
    if (!is_del) begin
      if (app_ok) begin
        res_count = app_idx;
      end else begin
        res_status = ST_FULL;
      end
    end else if (count == '0) begin
      res_max    = data_t'(-1);
      res_status = ST_EMPTY;
    end else begin
      res_max   = root;
      res_count = count - idx_t'(1);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (start_sift) state_next = S_FETCH;
      S_FETCH: state_next = S_SIFT;
      S_SIFT:  if (busy_vec == '0) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // The fetched last entry becomes the root and starts sinking from level one.
  always_comb begin
    tok_launch = '{valid: (state == S_FETCH), idx: idx_t'(1), value: rd_arr[lvl_q]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (acc) count <= res_count;
    end
  end

  always_ff @(posedge clk) begin
    if (start_sift) lvl_q <= lvl_of(count);
  end

  always_ff @(posedge clk) begin
    if (app_wr && (app_idx == idx_t'(1))) begin
      root <= value;
    end else if (state == S_FETCH) begin
      root <= rd_arr[lvl_q];
    end else if (wb_out_arr[1].valid) begin
      root <= wb_out_arr[1].value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!rsp_valid || !rsp_stall) begin
      if (skid_valid) begin
        rsp_valid  <= 1'b1;
        skid_valid <= 1'b0;
        out_max    <= skid_max;
        out_status <= skid_status;
        out_count  <= skid_count;
      end else begin
        rsp_valid <= acc;
        if (acc) begin
          out_max    <= res_max;
          out_status <= res_status;
          out_count  <= res_count;
        end
      end
    end else if (acc) begin
      skid_valid  <= 1'b1;
      skid_max    <= res_max;
      skid_status <= res_status;
      skid_count  <= res_count;
    end
  end

  assign max_value       = out_max;
  assign status          = out_status;
  assign entry_count_out = OUT_CNT_W'(out_count);

  assign rd_arr[0] = root;

  for (genvar g = 1; g < LEVELS; g++) begin : g_level
    if (g == 1) begin : g_first
      assign tok_in_arr[g] = tok_launch;
    end else begin : g_mid
      assign tok_in_arr[g] = tok_out_arr[g-1];
    end

    if (g == LEVELS - 1) begin : g_last
      assign wb_in_arr[g] = '0;
    end else begin : g_inner
      assign wb_in_arr[g] = wb_out_arr[g+1];
    end

    assign host_wr_arr[g] = '{valid: app_wr && (app_lvl == LVL_W'(g)),
                              idx: app_idx, value: value};

    mhdm_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .count        (count),
      .tok_in       (tok_in_arr[g]),
      .tok_out      (tok_out_arr[g]),
      .wb_in        (wb_in_arr[g]),
      .wb_out       (wb_out_arr[g]),
      .host_wr      (host_wr_arr[g]),
      .host_rd_idx  (count),
      .host_rd_data (rd_arr[g]),
      .busy         (busy_vec[g]),
      .ram_req      (ram_req_arr[g]),
      .ram_rdata_a  (rda_arr[g]),
      .ram_rdata_b  (rdb_arr[g])
    );

    mhdm_ram #(
      .WIDTH (DATA_W),
      .DEPTH (1 << g)
    ) u_ram (
      .clk     (clk),
      .we      (ram_req_arr[g].we),
      .waddr   (ram_req_arr[g].widx[g-1:0]),
      .wdata   (ram_req_arr[g].wdata),
      .raddr_a (ram_req_arr[g].ra[g-1:0]),
      .raddr_b (ram_req_arr[g].rb[g-1:0]),
      .rdata_a (rda_arr[g]),
      .rdata_b (rdb_arr[g])
    );
  end

endmodule
`default_nettype wire

// ===== tb/max_heap_delete_max_core_test.sv =====
// Self-checking testbench for the max-heap delete-max core with random idling and stalls.
module max_heap_delete_max_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import mhdm_pkg::*;

  localparam int     LIMIT_CYCLES = 400000;
  localparam int     RANDOM_WORDS = 800;
  localparam int     CALM_TAIL    = 150;
  localparam int     SHADOW       = 0;   // heap image used while building stimulus
  localparam int     LIVE         = 1;   // heap image advanced on accepted words
  localparam longint INT_LO       = -64'sd2147483648;

  typedef struct {
    op_t   op;
    data_t value;
  } heap_op_t;

  typedef struct {
    data_t                 max_value;
    status_t               status;
    logic [OUT_CNT_W-1:0]  count;
  } heap_reply_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 req_valid = 1'b0;
  logic                 req_stall;
  logic [0:0]           func      = OP_APPEND;
  data_t                value     = '0;
  logic                 rsp_valid;
  logic                 rsp_stall = 1'b0;
  data_t                max_value;
  logic [STATUS_W-1:0]  status;
  logic [OUT_CNT_W-1:0] entry_count_out;

  heap_op_t    ops_pending[$];
  heap_reply_t replies_due[$];
  data_t       heap_img [2][HEAP_DEPTH];
  int unsigned heap_cnt [2];
  int          mismatches = 0;
  int          cycles     = 0;
  int          words_in   = 0;
  int          req_gap    = 0;
  int          rsp_hold   = 0;

  max_heap_delete_max_core uut (
    .clk             (clk),
    .rst             (rst),
    .req_valid       (req_valid),
    .req_stall       (req_stall),
    .func            (func),
    .value           (value),
    .rsp_valid       (rsp_valid),
    .rsp_stall       (rsp_stall),
    .max_value       (max_value),
    .status          (status),
    .entry_count_out (entry_count_out)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Apply one operation to heap image k and return the reply it produces.
  function automatic heap_reply_t heap_apply(int k, op_t op, data_t v);
    heap_reply_t r;
    int unsigned pos, best, kid;
    data_t       t;
    bit          done;
    r.max_value = '0;
    r.status    = ST_OK;
    if (op == OP_APPEND) begin
      if (heap_cnt[k] >= HEAP_DEPTH - 1) begin
        r.status = ST_FULL;
      end else begin
        heap_cnt[k]++;
        heap_img[k][heap_cnt[k]] = v;
      end
    end else if (heap_cnt[k] == 0) begin
      r.max_value = -1;
      r.status    = ST_EMPTY;
    end else begin
      r.max_value    = heap_img[k][1];
      heap_img[k][1] = heap_img[k][heap_cnt[k]];
      heap_cnt[k]--;
      pos  = 1;
      done = 1'b0;
      while (!done) begin
        best = pos;
        for (kid = 2 * pos; kid <= 2 * pos + 1; kid++) begin
          // Strictly greater only, so the left child keeps a tie.
          if (kid <= heap_cnt[k] && kid < HEAP_DEPTH && heap_img[k][kid] > heap_img[k][best])
            best = kid;
        end
        if (best == pos) begin
          done = 1'b1;
        end else begin
          t                 = heap_img[k][pos];
          heap_img[k][pos]  = heap_img[k][best];
          heap_img[k][best] = t;
          pos               = best;
        end
      end
    end
    r.count = OUT_CNT_W'(heap_cnt[k]);
    return r;
  endfunction

  // Mostly a value no larger than its future parent, so the heap stays ordered;
  // now and then an arbitrary word to exercise unordered contents.
  function automatic data_t append_value();
    longint          parent, cand;
    longint unsigned r64;
    if (heap_cnt[SHADOW] == 0 || $urandom_range(0, 9) == 0)
      return data_t'($urandom);
    parent = longint'(heap_img[SHADOW][(heap_cnt[SHADOW] + 1) / 2]);
    case ($urandom_range(0, 3))
      0: cand = parent;
      1: begin
        cand = parent - longint'($urandom_range(0, 3));
        if (cand < INT_LO) cand = parent;
      end
      default: begin
        r64  = {$urandom, $urandom};
        cand = parent - longint'(r64 % longint'(parent - INT_LO + 1));
      end
    endcase
    return data_t'(cand);
  endfunction

  task automatic queue_op(op_t op, data_t v);
    void'(heap_apply(SHADOW, op, v));
    ops_pending.push_back('{op, v});
  endtask

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  // No new idle bursts near the end, and none in every fourth stretch of 48 words.
  function automatic bit idling_on();
    return ops_pending.size() >= CALM_TAIL && ((words_in / 48) % 4) != 2;
  endfunction

  // Request side: a word stays put until accepted, then the next one or a gap follows.
  always @(posedge clk) begin : drive_req
    heap_op_t nxt;
    if (rst) begin
      req_valid <= 1'b0;
      req_gap   <= 0;
    end else begin
      if (req_valid && !req_stall) begin
        replies_due.push_back(heap_apply(LIVE, op_t'(func), value));
        words_in <= words_in + 1;
      end
      if (!req_valid || !req_stall) begin
        if (req_gap != 0) begin
          req_valid <= 1'b0;
          req_gap   <= req_gap - 1;
        end else if (ops_pending.size() != 0 && idling_on() && $urandom_range(0, 7) == 0) begin
          req_valid <= 1'b0;
          req_gap   <= $urandom_range(0, 16);
        end else if (ops_pending.size() != 0) begin
          nxt       = ops_pending.pop_front();
          req_valid <= 1'b1;
          func      <= nxt.op;
          value     <= nxt.value;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
      rsp_hold  <= 0;
    end else if (rsp_hold != 0) begin
      rsp_stall <= 1'b1;
      rsp_hold  <= rsp_hold - 1;
    end else if (idling_on() && $urandom_range(0, 7) == 0) begin
      rsp_stall <= 1'b1;
      rsp_hold  <= $urandom_range(0, 16);
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_rsp
    heap_reply_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (replies_due.size() == 0) begin
        report_mismatch("response word with no request outstanding");
      end else begin
        want = replies_due.pop_front();
        if (max_value !== want.max_value)
          report_mismatch($sformatf("max_value %0d, expected %0d", max_value, want.max_value));
        if (status !== want.status)
          report_mismatch($sformatf("status %0d, expected %s", status, want.status.name()));
        if (entry_count_out !== want.count)
          report_mismatch($sformatf("entry_count_out %0d, expected %0d",
                                    entry_count_out, want.count));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    int phase;
    int start_words;
    heap_cnt[SHADOW] = 0;
    heap_cnt[LIVE]   = 0;

    // Directed: empty delete, ties between children, extreme values, drain past empty.
    queue_op(OP_DELETE, 32'hFFFF_FFFF);
    queue_op(OP_APPEND, 100);
    queue_op(OP_APPEND, 50);
    queue_op(OP_APPEND, 50);
    queue_op(OP_APPEND, 7);
    queue_op(OP_APPEND, 50);
    queue_op(OP_APPEND, 32'h7FFF_FFFF);
    queue_op(OP_APPEND, 32'h8000_0000);
    queue_op(OP_APPEND, -1);
    queue_op(OP_APPEND, 0);
    repeat (10) queue_op(OP_DELETE, data_t'($urandom));

    start_words = ops_pending.size();
    phase = 0;
    while (ops_pending.size() < start_words + RANDOM_WORDS) begin
      case (phase % 3)
        0: begin
          // Fill to capacity, then knock on the full heap a few times.
          while (heap_cnt[SHADOW] < HEAP_DEPTH - 1) begin
            if ($urandom_range(0, 9) == 0) queue_op(OP_DELETE, data_t'($urandom));
            else queue_op(OP_APPEND, append_value());
          end
          repeat ($urandom_range(1, 3)) queue_op(OP_APPEND, data_t'($urandom));
        end
        1: begin
          repeat ($urandom_range(30, 80)) begin
            if ($urandom_range(0, 1) == 0) queue_op(OP_DELETE, data_t'($urandom));
            else queue_op(OP_APPEND, append_value());
          end
        end
        default: begin
          while (heap_cnt[SHADOW] > 0) begin
            if ($urandom_range(0, 9) == 0) queue_op(OP_APPEND, append_value());
            else queue_op(OP_DELETE, data_t'($urandom));
          end
          repeat ($urandom_range(1, 2)) queue_op(OP_DELETE, data_t'($urandom));
        end
      endcase
      phase++;
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (ops_pending.size() != 0 || req_valid || replies_due.size() != 0)
      @(posedge clk);
    // Leave room for any stray word beyond the deepest sift.
    repeat (4 * (LEVELS + 2)) @(posedge clk);

    if (mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== max_heap_delete_max_core.f =====
hdl/mhdm_pkg.sv
hdl/mhdm_ram.sv
hdl/mhdm_cell.sv
hdl/max_heap_delete_max_core.sv
tb/max_heap_delete_max_core_test.sv
